// ===== rtl/core/rbsi_pkg.sv =====
// Shared constants for the ray versus box slab intersection block.
`timescale 1ns / 1ps
package rbsi_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int AXES       = 3;
endpackage

// ===== rtl/core/rbsi_if.sv =====
// Channel interfaces: ray/box input and hit/distance result.
`timescale 1ns / 1ps
interface rbsi_in_if #(
	parameter int DW = 32,
	parameter int FB = 16
);
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] origin_x, origin_y, origin_z;
	logic signed [FB+1:0] dir_x, dir_y, dir_z;
	logic signed [DW-1:0] box_min_x, box_min_y, box_min_z;
	logic signed [DW-1:0] box_max_x, box_max_y, box_max_z;
	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface rbsi_out_if #(
	parameter int DW = 32
);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic signed [DW-1:0] near_distance;
	modport source (output valid, hit, near_distance, input ready);
	modport sink (input valid, hit, near_distance, output ready);
endinterface

// ===== rtl/core/rbsi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating signed result.
`timescale 1ns / 1ps
module rbsi_div #(
	parameter int DW = rbsi_pkg::DATA_WIDTH,
	parameter int FB = rbsi_pkg::FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DW-1:0]        num_mag,
	input  logic [FB+1:0]        den_mag,
	input  logic                 neg,
	output logic signed [DW-1:0] quo
);
	localparam int N  = DW + FB;
	localparam int RW = FB + 2;

	logic [N-1:0]  dvd_s [N+1];
	logic [N-1:0]  q_s   [N+1];
	logic [RW-1:0] rem_s [N+1];
	logic [RW-1:0] den_s [N+1];
	logic          neg_s [N+1];

	assign dvd_s[0] = {num_mag, {FB{1'b0}}};
	assign q_s[0]   = '0;
	assign rem_s[0] = '0;
	assign den_s[0] = den_mag;
	assign neg_s[0] = neg;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW:0] trial;
		logic [RW:0] diff;
		logic        ge;
		always_comb begin
			trial = {rem_s[k], dvd_s[k][N-1]};
			diff  = trial - {1'b0, den_s[k]};
			ge    = trial >= {1'b0, den_s[k]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[RW-1:0] : trial[RW-1:0];
				q_s[k+1]   <= {q_s[k][N-2:0], ge};
				dvd_s[k+1] <= {dvd_s[k][N-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// limit is 2^(DW-1)-1, one more for negative results
	logic [N-1:0] lim;
	logic [N-1:0] sat;
	always_comb begin
		lim = {{(FB+1){1'b0}}, {(DW-1){1'b1}}} + {{(N-1){1'b0}}, neg_s[N]};
		sat = (q_s[N] > lim) ? lim : q_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= neg_s[N] ? -sat[DW-1:0] : sat[DW-1:0];
		end
	end
endmodule

// ===== rtl/core/ray_box_slab_intersect.sv =====
// Top level: pipelined ray versus axis-aligned box slab test.
`timescale 1ns / 1ps
// Usage:
//  in  : ray origin, direction and box corners, signed fixed point with
//        FRAC_BITS fraction bits; a transfer happens when valid and ready are high.
//  out : hit flag and near distance (zero on a miss), one result per input.
//  Throughput: one ray per cycle unless the output stalls, set by six fully
//  pipelined dividers (entry and exit per axis), one quotient bit per stage.
//  Pipeline: 1 setup stage, DATA_WIDTH+FRAC_BITS divider steps,
//    1 saturation stage, 1 min/max stage, 1 output register.
//  Stall: when the output holds a result that is not taken, the whole
//  pipeline freezes and in.ready drops; nothing is lost or repeated.
//  Reset: arst_n clears all valid bits; the pipeline comes up empty.
//  A zero direction component leaves its axis unbounded when the origin lies
//  inside the slab and forces a miss otherwise.
module ray_box_slab_intersect #(
	parameter int DATA_WIDTH = rbsi_pkg::DATA_WIDTH,
	parameter int FRAC_BITS  = rbsi_pkg::FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	rbsi_in_if.sink   in,
	rbsi_out_if.source out
);
	import rbsi_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int L  = DW + FB + 1;  // divider latency

	localparam logic signed [DW-1:0] TMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] TMIN = {1'b1, {(DW-1){1'b0}}};

	logic adv;
	logic out_valid_q;
	assign adv      = !out_valid_q || out.ready;
	assign in.ready = adv;

	logic signed [DW-1:0] o   [AXES];
	logic signed [DW-1:0] lo  [AXES];
	logic signed [DW-1:0] hi  [AXES];
	logic signed [FB+1:0] d   [AXES];
	always_comb begin
		o[0] = in.origin_x;  o[1] = in.origin_y;  o[2] = in.origin_z;
		d[0] = in.dir_x;     d[1] = in.dir_y;     d[2] = in.dir_z;
		lo[0] = in.box_min_x; lo[1] = in.box_min_y; lo[2] = in.box_min_z;
		hi[0] = in.box_max_x; hi[1] = in.box_max_y; hi[2] = in.box_max_z;
	end

	// setup stage: slab numerators, signs and divisor magnitudes
	logic            v_s1;
	logic [DW-1:0]   ne_mag_s1 [AXES];
	logic [DW-1:0]   nx_mag_s1 [AXES];
	logic            ne_neg_s1 [AXES];
	logic            nx_neg_s1 [AXES];
	logic [FB+1:0]   dmag_s1   [AXES];
	logic [AXES-1:0] dzero_s1;
	logic            zmiss_s1;

	logic signed [DW:0] de [AXES];
	logic signed [DW:0] dx [AXES];
	logic [AXES-1:0]    outside;
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			de[a] = (d[a][FB+1] ? {hi[a][DW-1], hi[a]} : {lo[a][DW-1], lo[a]})
				- {o[a][DW-1], o[a]};
			dx[a] = (d[a][FB+1] ? {lo[a][DW-1], lo[a]} : {hi[a][DW-1], hi[a]})
				- {o[a][DW-1], o[a]};
			outside[a] = (o[a] < lo[a]) || (o[a] > hi[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				ne_mag_s1[a] <= de[a][DW] ? DW'(-de[a]) : de[a][DW-1:0];
				nx_mag_s1[a] <= dx[a][DW] ? DW'(-dx[a]) : dx[a][DW-1:0];
				ne_neg_s1[a] <= de[a][DW] ^ d[a][FB+1];
				nx_neg_s1[a] <= dx[a][DW] ^ d[a][FB+1];
				dmag_s1[a]   <= d[a][FB+1] ? -d[a] : d[a];
				dzero_s1[a]  <= d[a] == '0;
			end
			zmiss_s1 <= |(outside & {d[2] == '0, d[1] == '0, d[0] == '0});
		end
	end

	// dividers: entry and exit distance per axis
	logic signed [DW-1:0] te [AXES];
	logic signed [DW-1:0] tx [AXES];
	for (genvar a = 0; a < AXES; a++) begin : g_axis
		rbsi_div #(.DW(DW), .FB(FB)) u_div_e (
			.clk(clk), .en(adv), .num_mag(ne_mag_s1[a]), .den_mag(dmag_s1[a]),
			.neg(ne_neg_s1[a]), .quo(te[a]));
		rbsi_div #(.DW(DW), .FB(FB)) u_div_x (
			.clk(clk), .en(adv), .num_mag(nx_mag_s1[a]), .den_mag(dmag_s1[a]),
			.neg(nx_neg_s1[a]), .quo(tx[a]));
	end

	// side band travels alongside the dividers
	logic [L-1:0]    v_dq;
	logic [AXES-1:0] dzero_dq [L];
	logic            zmiss_dq [L];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_dq <= '0;
		end else if (adv) begin
			v_s1 <= in.valid;
			v_dq <= {v_dq[L-2:0], v_s1};
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dzero_dq[0] <= dzero_s1;
			zmiss_dq[0] <= zmiss_s1;
			for (int k = 1; k < L; k++) begin
				dzero_dq[k] <= dzero_dq[k-1];
				zmiss_dq[k] <= zmiss_dq[k-1];
			end
		end
	end

	// reduce stage: largest entry, smallest exit over bounded axes
	logic                 v_s2;
	logic signed [DW-1:0] near_s2, far_s2;
	logic                 zmiss_s2;
	logic signed [DW-1:0] near_c, far_c;
	always_comb begin
		near_c = TMIN;
		far_c  = TMAX;
		for (int a = 0; a < AXES; a++) begin
			if (!dzero_dq[L-1][a]) begin
				if (te[a] > near_c) near_c = te[a];
				if (tx[a] < far_c)  far_c  = tx[a];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			near_s2  <= near_c;
			far_s2   <= far_c;
			zmiss_s2 <= zmiss_dq[L-1];
		end
	end

	// output register
	logic                 miss_c;
	logic                 hit_q;
	logic signed [DW-1:0] near_q;
	assign miss_c = zmiss_s2 || (near_s2 > far_s2) || far_s2[DW-1];
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q  <= !miss_c;
			near_q <= miss_c ? '0 : near_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2        <= v_dq[L-1];
			out_valid_q <= v_s2;
		end
	end

	assign out.valid         = out_valid_q;
	assign out.hit           = hit_q;
	assign out.near_distance = near_q;
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the ray versus box slab intersection block.
`timescale 1ns / 1ps
module testbench;
	import rbsi_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam longint ONE = longint'(1) << FB;
	localparam longint TMAX = (longint'(1) << (DW - 1)) - 1;
	localparam longint TMIN = -TMAX - 1;
	localparam int LATENCY = DW + FB + 4;
	localparam int N_RANDOM = 650;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [DW-1:0] org [AXES];
		logic signed [FB+1:0] dir [AXES];
		logic signed [DW-1:0] bmin [AXES];
		logic signed [DW-1:0] bmax [AXES];
	} ray_box_t;

	typedef struct {
		logic                 hit;
		logic signed [DW-1:0] near_distance;
	} hit_t;

	typedef struct {
		ray_box_t rb;
		bit       typed;   // expected result written into the row
		hit_t     res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rbsi_in_if  #(.DW(DW), .FB(FB)) in_ch();
	rbsi_out_if #(.DW(DW))          out_ch();

	ray_box_slab_intersect #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (in_ch),
		.out   (out_ch)
	);

	always #5 clk = ~clk;

	hit_t      hits_due [$];    // expected results in transfer order
	stim_row_t typed_due [$];   // typed rows waiting for their input transfer
	int        errors = 0;
	int        sent = 0;
	bit        stim_done = 1'b0;
	int        cycles = 0;

	// Distance to a slab plane: (hi - lo) * 2^FB / den, truncated toward
	// zero, then clamped to the signed data range.
	function automatic longint plane_distance(longint hi, longint lo, longint den);
		longint unsigned num_mag, den_mag, quo, lim;
		bit neg;
		num_mag = (hi >= lo) ? longint'(hi - lo) : longint'(lo - hi);
		den_mag = (den < 0) ? longint'(-den) : longint'(den);
		neg = (hi < lo) != (den < 0);
		quo = (num_mag << FB) / den_mag;
		lim = neg ? longint'(-TMIN) : longint'(TMAX);
		if (quo > lim)
			quo = lim;
		return neg ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic hit_t slab_test(ray_box_t rb);
		hit_t r;
		longint near_t, far_t, o, d, lo, hi, t_in, t_out;
		bit miss;
		near_t = TMIN;
		far_t = TMAX;
		miss = 1'b0;
		for (int a = 0; a < AXES; a++) begin
			o = rb.org[a];
			d = rb.dir[a];
			lo = rb.bmin[a];
			hi = rb.bmax[a];
			if (d == 0) begin
				// parallel to the slab: unbounded inside, miss outside
				if (o < lo || o > hi)
					miss = 1'b1;
				continue;
			end
			if (d > 0) begin
				t_in = plane_distance(lo, o, d);
				t_out = plane_distance(hi, o, d);
			end else begin
				t_in = plane_distance(hi, o, d);
				t_out = plane_distance(lo, o, d);
			end
			if (t_in > near_t)
				near_t = t_in;
			if (t_out < far_t)
				far_t = t_out;
		end
		if (near_t > far_t || far_t < 0)
			miss = 1'b1;
		r.hit = !miss;
		r.near_distance = miss ? '0 : near_t[DW-1:0];
		return r;
	endfunction

	function automatic ray_box_t axis_ray(longint o, longint d, longint lo, longint hi);
		ray_box_t rb;
		for (int a = 0; a < AXES; a++) begin
			rb.org[a] = DW'((a == 0) ? o : longint'(0));
			rb.dir[a] = (FB + 2)'((a == 0) ? d : longint'(0));
			rb.bmin[a] = DW'((a == 0) ? lo : -ONE);
			rb.bmax[a] = DW'((a == 0) ? hi : ONE);
		end
		return rb;
	endfunction

	function automatic ray_box_t fill_ray(longint o, longint d, longint lo, longint hi);
		ray_box_t rb;
		for (int a = 0; a < AXES; a++) begin
			rb.org[a] = DW'(o);
			rb.dir[a] = (FB + 2)'(d);
			rb.bmin[a] = DW'(lo);
			rb.bmax[a] = DW'(hi);
		end
		return rb;
	endfunction

	function automatic stim_row_t mk_row(ray_box_t rb, bit typed, logic h, longint nd);
		stim_row_t s;
		s.rb = rb;
		s.typed = typed;
		s.res.hit = h;
		s.res.near_distance = DW'(nd);
		return s;
	endfunction

	// Random ray: mostly aimed through a box, the rest raw noise,
	// parallel axes and inverted boxes.
	function automatic ray_box_t rand_ray();
		ray_box_t rb;
		int kind;
		longint c, half, k, t;
		kind = $urandom_range(0, 9);
		k = longint'($urandom_range(1, 300));
		for (int a = 0; a < AXES; a++) begin
			c = longint'($signed($urandom_range(0, 4000))) * ONE / 2 - 1000 * ONE;
			half = longint'($urandom_range(1, 32'(50 * ONE)));
			rb.dir[a] = (FB + 2)'(longint'($signed($urandom_range(0, 32'(2 * ONE)))) - ONE);
			case (kind)
				6, 7: begin
					rb.org[a] = DW'($urandom());
					rb.dir[a] = (FB + 2)'($urandom());
					rb.bmin[a] = DW'($urandom());
					rb.bmax[a] = DW'($urandom());
				end
				default: begin
					if (kind == 8 && $urandom_range(0, 1))
						rb.dir[a] = '0;
					t = c - longint'(rb.dir[a]) * k
						+ longint'($signed($urandom_range(0, 32'(2 * ONE)))) - ONE;
					rb.org[a] = DW'(t);
					rb.bmin[a] = DW'((kind == 9) ? c + half : c - half);
					rb.bmax[a] = DW'((kind == 9) ? c - half : c + half);
				end
			endcase
		end
		return rb;
	endfunction

	// Wait for the current offer to be taken. Ready is read at the falling
	// edge, where it is settled for the next rising edge.
	task automatic offer(ray_box_t rb, bit typed, stim_row_t row);
		bit taken;
		in_ch.valid <= 1'b1;
		in_ch.origin_x <= rb.org[0];
		in_ch.origin_y <= rb.org[1];
		in_ch.origin_z <= rb.org[2];
		in_ch.dir_x <= rb.dir[0];
		in_ch.dir_y <= rb.dir[1];
		in_ch.dir_z <= rb.dir[2];
		in_ch.box_min_x <= rb.bmin[0];
		in_ch.box_min_y <= rb.bmin[1];
		in_ch.box_min_z <= rb.bmin[2];
		in_ch.box_max_x <= rb.bmax[0];
		in_ch.box_max_y <= rb.bmax[1];
		in_ch.box_max_z <= rb.bmax[2];
		if (typed)
			typed_due.push_back(row);
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
		sent++;
	endtask

	task automatic idle_gap();
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Transfer monitor: predict on input transfers, check on output transfers.
	always @(posedge clk) begin
		hit_t exp_r;
		stim_row_t row;
		ray_box_t rb;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			rb.org[0] = in_ch.origin_x;
			rb.org[1] = in_ch.origin_y;
			rb.org[2] = in_ch.origin_z;
			rb.dir[0] = in_ch.dir_x;
			rb.dir[1] = in_ch.dir_y;
			rb.dir[2] = in_ch.dir_z;
			rb.bmin[0] = in_ch.box_min_x;
			rb.bmin[1] = in_ch.box_min_y;
			rb.bmin[2] = in_ch.box_min_z;
			rb.bmax[0] = in_ch.box_max_x;
			rb.bmax[1] = in_ch.box_max_y;
			rb.bmax[2] = in_ch.box_max_z;
			exp_r = slab_test(rb);
			if (!stim_done && typed_due.size() > 0) begin
				row = typed_due.pop_front();
				exp_r = row.res;
			end
			hits_due.push_back(exp_r);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (hits_due.size() == 0) begin
				$display("%0t: unexpected result hit=%0b near=%0d", $time,
					out_ch.hit, out_ch.near_distance);
				errors++;
			end else begin
				exp_r = hits_due.pop_front();
				if (out_ch.hit !== exp_r.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, out_ch.hit);
					errors++;
				end
				if (out_ch.near_distance !== exp_r.near_distance) begin
					$display("%0t: near_distance expected %0d actual %0d", $time,
						exp_r.near_distance, out_ch.near_distance);
					errors++;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off once traffic is going.
	initial begin
		int hold;
		bit held;
		held = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent >= 150) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				hold = 0;
				while (hold < 300) begin
					@(posedge clk);
					hold++;
				end
			end
			if (sent > 500 && sent < 560)
				out_ch.ready <= 1'b1;   // stretch with no stalls
			else if ($urandom_range(0, 30) == 0)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		ray_box_t rb;
		int waited;

		in_ch.valid <= 1'b0;
		in_ch.origin_x <= '0;
		in_ch.origin_y <= '0;
		in_ch.origin_z <= '0;
		in_ch.dir_x <= '0;
		in_ch.dir_y <= '0;
		in_ch.dir_z <= '0;
		in_ch.box_min_x <= '0;
		in_ch.box_min_y <= '0;
		in_ch.box_min_z <= '0;
		in_ch.box_max_x <= '0;
		in_ch.box_max_y <= '0;
		in_ch.box_max_z <= '0;

		// directed rows; typed ones carry their own answer
		rows.push_back(mk_row(fill_ray(0, 0, -ONE, ONE), 1, 1'b1, TMIN));     // all parallel, inside
		rows.push_back(mk_row(axis_ray(2 * ONE, 0, -ONE, ONE), 1, 1'b0, 0)); // parallel, outside
		rows.push_back(mk_row(axis_ray(-10 * ONE, ONE, 5 * ONE, ONE), 1, 1'b0, 0)); // inverted box
		rows.push_back(mk_row(axis_ray(-10 * ONE, ONE, 0, ONE), 1, 1'b1, 10 * ONE));
		rows.push_back(mk_row(axis_ray(10 * ONE, -ONE, 0, ONE), 1, 1'b1, 9 * ONE));
		rows.push_back(mk_row(axis_ray(0, ONE, -ONE, ONE), 1, 1'b1, -ONE));  // origin inside
		rows.push_back(mk_row(axis_ray(10 * ONE, ONE, 0, ONE), 1, 1'b0, 0)); // box behind
		rows.push_back(mk_row(axis_ray(TMIN, 1, 0, TMAX), 0, 0, 0));         // saturation
		rows.push_back(mk_row(axis_ray(TMAX, -1, TMIN, 0), 0, 0, 0));
		rows.push_back(mk_row(axis_ray(-ONE, -131072, TMIN, TMAX), 0, 0, 0));
		rows.push_back(mk_row(axis_ray(-ONE, 131071, -ONE, ONE), 0, 0, 0));
		rows.push_back(mk_row(fill_ray(TMAX, 131071, TMAX, TMAX), 0, 0, 0));
		rows.push_back(mk_row(fill_ray(TMIN, -131072, TMIN, TMIN), 0, 0, 0));
		rows.push_back(mk_row(fill_ray(-3 * ONE, ONE / 2, -ONE, ONE), 0, 0, 0));
		rows.push_back(mk_row(fill_ray(TMIN, ONE, TMIN, TMAX), 0, 0, 0));
		rows.push_back(mk_row(fill_ray(-1, -1, TMIN, TMAX), 0, 0, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			offer(rows[i].rb, rows[i].typed, rows[i]);
			idle_gap();
		end
		in_ch.valid <= 1'b0;
		// let the typed rows drain before the predictor takes over alone
		while (hits_due.size() > 0 || typed_due.size() > 0) @(posedge clk);
		stim_done = 1'b1;

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 400) begin
				// sender pause until the pipeline has fully drained
				in_ch.valid <= 1'b0;
				while (hits_due.size() > 0) @(posedge clk);
			end
			rb = rand_ray();
			offer(rb, 1'b0, rows[0]);
			if (n < 150 || n > 330)
				idle_gap();   // keep offering during the long hold-off
		end
		in_ch.valid <= 1'b0;

		waited = 0;
		while (hits_due.size() > 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0 && hits_due.size() == 0) begin
			$display("testbench: clean");
		end else begin
			if (hits_due.size() > 0)
				$display("%0t: %0d results never arrived", $time, hits_due.size());
			$display("testbench: errors");
		end
		$finish;
	end
endmodule
